// File: hdl/multi_queue_strict_priority_buffer_defines.svh
// Assertion macros for the multi-queue buffer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MULTI_QUEUE_STRICT_PRIORITY_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_STRICT_PRIORITY_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MQSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mqsp assertion failed");
// next-cycle implication
`define MQSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mqsp assertion failed");
`else
`define MQSP_ASSERT_NOW(label, ante, cons)
`define MQSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/mqsp_pkg.sv
package mqsp_pkg;

	// field widths
	localparam int CMD_W      = 2;
	localparam int QID_W      = 4;
	localparam int PRIO_W     = 4;
	localparam int MSG_W      = 32;
	localparam int STS_W      = 3;
	localparam int CNT_OUT_W  = 7;
	localparam int CAP_W      = 7;
	localparam int LVLREG_W   = 4;
	localparam int MASK_W     = 8;
	localparam int MASK_IW    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	// level values 0..15
	localparam int LV_W       = 5;

	// commands
	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECV = 2'd1;

	// result status codes
	localparam logic [STS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STS_W-1:0] ST_BAD_ID      = 3'd1;
	localparam logic [STS_W-1:0] ST_NOT_CREATED = 3'd2;
	localparam logic [STS_W-1:0] ST_FULL        = 3'd3;
	localparam logic [STS_W-1:0] ST_EMPTY       = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;

	// register reset values
	localparam logic [CAP_W-1:0]    CAP_RESET    = 7'd16;
	localparam logic [LVLREG_W-1:0] LEVELS_RESET = 4'd8;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_WR
	} mqsp_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd1;
		logic rd2;
		logic commit;
	} mqsp_cmd_t;

endpackage

// File: hdl/mqsp_ctrl.sv
module mqsp_ctrl import mqsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_busy,
	output mqsp_cmd_t ctl
);

	mqsp_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_RD1;
			end
			S_RD1: state_nxt = S_RD2;
			S_RD2: state_nxt = S_WR;
			S_WR: begin
				if (!out_busy) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		ctl        = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			S_RD1: ctl.rd1 = 1'b1;
			S_RD2: ctl.rd2 = 1'b1;
			S_WR: ctl.commit = !out_busy;
			default: ;
		endcase
	end

endmodule

// File: hdl/mqsp_dp.sv
module mqsp_dp import mqsp_pkg::*; #(
	parameter int NUM_QUEUES   = 8,
	parameter int MAX_LEVELS   = 8,
	parameter int POOL_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mqsp_cmd_t            ctl,
	output logic                 out_busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [QID_W-1:0]     queue_id,
	input  logic [PRIO_W-1:0]    priority_req,
	input  logic [MSG_W-1:0]     message,
	input  logic [CAP_W-1:0]     cfg_capacity,
	input  logic [LVLREG_W-1:0]  cfg_levels,
	input  logic [MASK_W-1:0]    cfg_mask,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STS_W-1:0]     status,
	output logic [MSG_W-1:0]     message_out,
	output logic [CNT_OUT_W-1:0] occupancy,
	output logic [CNT_OUT_W-1:0] level_count
);

	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int NUM_LISTS = NUM_QUEUES * MAX_LEVELS;
	localparam int LIW       = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PW        = $clog2(POOL_ENTRIES);
	localparam int CW        = $clog2(POOL_ENTRIES + 1);
	localparam int MW        = (CW > CAP_W) ? CW : CAP_W;

	// item registers
	logic [CMD_W-1:0]  cmd_q;
	logic [QID_W-1:0]  qid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [MSG_W-1:0]  word_q;

	// list and pool state
	logic [NUM_LISTS-1:0]    ne_q;
	logic [POOL_ENTRIES-1:0] nxv_q;
	logic [CW-1:0]           qcnt_q [NUM_QUEUES];
	logic [PW-1:0]           free_head_q;
	logic [CW-1:0]           free_cnt_q;

	// memories
	logic [PW-1:0]    head_mem [NUM_LISTS];
	logic [PW-1:0]    tail_mem [NUM_LISTS];
	logic [CW-1:0]    cnt_mem  [NUM_LISTS];
	logic [PW-1:0]    next_mem [POOL_ENTRIES];
	logic [MSG_W-1:0] data_mem [POOL_ENTRIES];

	// read data
	logic [PW-1:0]    head_rd_q, tail_rd_q, next_rd_q;
	logic [CW-1:0]    cnt_op_raw_q, cnt_addr_raw_q;
	logic             ne_op_q, ne_addr_q;
	logic [MSG_W-1:0] data_rd_q;

	// output registers
	logic                 out_valid_q;
	logic [STS_W-1:0]     status_q;
	logic [MSG_W-1:0]     msg_q;
	logic [CNT_OUT_W-1:0] occ_q, lvl_q;

	// decode
	logic                 bad_id, enabled, ok_path, is_send, is_recv, full;
	logic                 do_push, do_pop, found;
	logic [QW-1:0]        q_idx;
	logic [LV_W-1:0]      levels, prc, top, lvl_op, p_ext, lv_ext;
	logic [MAX_LEVELS-1:0] ne_row;
	logic [LIW-1:0]       li_op, li_addr;
	logic [CW-1:0]        qcnt_cur, qcnt_new, cnt_op, cnt_addr, cnt_new;
	logic [PW-1:0]        next_addr, chain_next, nx_wr_addr;
	logic                 nx_we;
	logic [STS_W-1:0]     status_nxt;

	assign q_idx   = QW'(qid_q);
	assign bad_id  = {1'b0, qid_q} >= (QID_W+1)'(NUM_QUEUES);
	assign enabled = ({1'b0, qid_q} < (QID_W+1)'(MASK_W)) && cfg_mask[qid_q[MASK_IW-1:0]];
	assign ok_path = !bad_id && enabled;
	assign is_send = (cmd_q == CMD_SEND);
	assign is_recv = (cmd_q == CMD_RECV);

	// level count in use and priority clamp
	assign lv_ext = {1'b0, cfg_levels};
	assign p_ext  = {1'b0, prio_q};
	always_comb begin
		priority if (lv_ext == '0) levels = LV_W'(1);
		else if (lv_ext > LV_W'(MAX_LEVELS)) levels = LV_W'(MAX_LEVELS);
		else levels = lv_ext;
		priority if (p_ext > levels) prc = levels;
		else if (p_ext == '0) prc = LV_W'(1);
		else prc = p_ext;
	end

	// highest non-empty level at or below the level count
	always_comb begin
		found = 1'b0;
		top   = LV_W'(1);
		for (int l = 0; l < MAX_LEVELS; l++) begin
			ne_row[l] = ne_q[LIW'(32'(q_idx) * 32'(MAX_LEVELS) + 32'(l))];
			if (ne_row[l] && (LV_W'(l) < levels)) begin
				found = 1'b1;
				top   = LV_W'(l + 1);
			end
		end
	end

	assign qcnt_cur = qcnt_q[q_idx];
	assign full     = (MW'(qcnt_cur) >= MW'(cfg_capacity)) || (free_cnt_q == '0);
	assign do_push  = ok_path && is_send && !full;
	assign do_pop   = ok_path && is_recv && found;
	assign lvl_op   = is_send ? prc : top;
	assign li_op    = LIW'(32'(q_idx) * 32'(MAX_LEVELS) + 32'(lvl_op) - 32'd1);
	assign li_addr  = LIW'(32'(q_idx) * 32'(MAX_LEVELS) + 32'(prc) - 32'd1);

	always_comb begin
		priority if (bad_id) status_nxt = ST_BAD_ID;
		else if (!enabled) status_nxt = ST_NOT_CREATED;
		else if (is_send && full) status_nxt = ST_FULL;
		else if (is_recv && !found) status_nxt = ST_EMPTY;
		else status_nxt = ST_OK;
	end

	// counts read back, empty lists read zero
	assign cnt_op   = ne_op_q ? cnt_op_raw_q : '0;
	assign cnt_addr = ne_addr_q ? cnt_addr_raw_q : '0;
	assign cnt_new  = do_push ? cnt_op + CW'(1) : cnt_op - CW'(1);
	always_comb begin
		priority if (do_push) qcnt_new = qcnt_cur + CW'(1);
		else if (do_pop) qcnt_new = qcnt_cur - CW'(1);
		else qcnt_new = qcnt_cur;
	end

	// link read address, untouched links follow the reset chain
	assign next_addr  = do_pop ? head_rd_q : free_head_q;
	assign chain_next = (next_addr == PW'(POOL_ENTRIES - 1)) ? '0 : next_addr + PW'(1);
	assign nx_wr_addr = do_push ? tail_rd_q : head_rd_q;
	assign nx_we      = ctl.commit && (do_pop || (do_push && cnt_op != '0));

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			qid_q  <= queue_id;
			prio_q <= priority_req;
			word_q <= message;
		end
	end

	// memory reads
	always_ff @(posedge clk) begin
		if (ctl.rd1) begin
			head_rd_q      <= head_mem[li_op];
			tail_rd_q      <= tail_mem[li_op];
			cnt_op_raw_q   <= cnt_mem[li_op];
			cnt_addr_raw_q <= cnt_mem[li_addr];
			ne_op_q        <= ne_q[li_op];
			ne_addr_q      <= ne_q[li_addr];
		end
		if (ctl.rd2) begin
			next_rd_q <= nxv_q[next_addr] ? next_mem[next_addr] : chain_next;
			data_rd_q <= data_mem[head_rd_q];
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (ctl.commit && do_push) begin
			data_mem[free_head_q] <= word_q;
			tail_mem[li_op]       <= free_head_q;
			if (cnt_op == '0) head_mem[li_op] <= free_head_q;
		end
		if (ctl.commit && do_pop) head_mem[li_op] <= next_rd_q;
		if (ctl.commit && (do_push || do_pop)) cnt_mem[li_op] <= cnt_new;
		if (nx_we) next_mem[nx_wr_addr] <= free_head_q;
	end

	// pool and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q        <= '0;
			nxv_q       <= '0;
			free_head_q <= '0;
			free_cnt_q  <= CW'(POOL_ENTRIES);
			for (int i = 0; i < NUM_QUEUES; i++) qcnt_q[i] <= '0;
		end else if (ctl.commit) begin
			if (nx_we) nxv_q[nx_wr_addr] <= 1'b1;
			if (do_push) begin
				ne_q[li_op]    <= 1'b1;
				free_head_q    <= next_rd_q;
				free_cnt_q     <= free_cnt_q - CW'(1);
				qcnt_q[q_idx]  <= qcnt_new;
			end else if (do_pop) begin
				ne_q[li_op]    <= (cnt_op != CW'(1));
				free_head_q    <= head_rd_q;
				free_cnt_q     <= free_cnt_q + CW'(1);
				qcnt_q[q_idx]  <= qcnt_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_nxt;
			msg_q    <= do_pop ? data_rd_q : '0;
			occ_q    <= ok_path ? CNT_OUT_W'(qcnt_new) : '0;
			if (!ok_path) lvl_q <= '0;
			else if ((do_push || do_pop) && li_addr == li_op) lvl_q <= CNT_OUT_W'(cnt_new);
			else lvl_q <= CNT_OUT_W'(cnt_addr);
		end
	end

	assign out_busy    = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign message_out = msg_q;
	assign occupancy   = occ_q;
	assign level_count = lvl_q;

endmodule

// File: hdl/multi_queue_strict_priority_buffer.sv
// Channel  Handshake             Payload
// in       in_valid/in_ready     cmd, queue_id, priority_req, message
// out      out_valid/out_ready   status, message_out, occupancy, level_count
// cfg      cfg_we                cfg_index, cfg_data
//
// Each beat passes four steps: accept, list pointer read, link and data read, commit.
// The list memories take one read pass and one write pass per operation,
// which sets the pace; one beat is in work at a time.
// A held result stalls the commit cycle until out_ready.
// arst_n clears counters, the free list and the control state; no clear pass.
`include "multi_queue_strict_priority_buffer_defines.svh"
module multi_queue_strict_priority_buffer import mqsp_pkg::*; #(
	parameter int NUM_QUEUES   = 8,
	parameter int MAX_LEVELS   = 8,
	parameter int POOL_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [QID_W-1:0]      queue_id,
	input  logic [PRIO_W-1:0]     priority_req,
	input  logic [MSG_W-1:0]      message,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STS_W-1:0]      status,
	output logic [MSG_W-1:0]      message_out,
	output logic [CNT_OUT_W-1:0]  occupancy,
	output logic [CNT_OUT_W-1:0]  level_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CAP_W-1:0]    capacity_q;
	logic [LVLREG_W-1:0] levels_q;
	logic [MASK_W-1:0]   mask_q;
	mqsp_cmd_t           ctl;
	logic                out_busy;
	logic                rejected;
	logic                fields_zero;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			levels_q   <= LEVELS_RESET;
			mask_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
				REG_LEVELS:   levels_q   <= cfg_data[LVLREG_W-1:0];
				REG_ENABLE:   mask_q     <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	mqsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_busy (out_busy),
		.ctl      (ctl)
	);

	mqsp_dp #(
		.NUM_QUEUES   (NUM_QUEUES),
		.MAX_LEVELS   (MAX_LEVELS),
		.POOL_ENTRIES (POOL_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.out_busy     (out_busy),
		.cmd          (cmd),
		.queue_id     (queue_id),
		.priority_req (priority_req),
		.message      (message),
		.cfg_capacity (capacity_q),
		.cfg_levels   (levels_q),
		.cfg_mask     (mask_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.message_out  (message_out),
		.occupancy    (occupancy),
		.level_count  (level_count)
	);

	// rejected beats and their payload
	assign rejected    = out_valid && (status == ST_BAD_ID || status == ST_NOT_CREATED);
	assign fields_zero = message_out == '0 && occupancy == '0 && level_count == '0;

	// one beat in work at a time
	`MQSP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// a level never holds more than its queue
	`MQSP_ASSERT_NOW(a_level_le_occ, out_valid, level_count <= occupancy)
	// rejected ids and disabled queues report nothing
	`MQSP_ASSERT_NOW(a_reject_zero, rejected, fields_zero)

endmodule
